FILE: design/tpid_pkg.sv
package tpid_pkg;

	// Thermistor divider and converter
	localparam int ADC_BITS             = 10;
	localparam int ADC_W                = ADC_BITS;
	localparam int ADC_DEPTH            = 1 << ADC_BITS;
	localparam longint SERIES_RESISTOR_OHMS = 64'sd4700;

	// Temperature fit T = A - B * log2(R), both in Q16 of 1/64 degree
	localparam longint TEMP_A_Q16 = 64'sd1628438401;
	localparam longint TEMP_B_Q16 = 64'sd95012051;

	// Field and datapath widths
	localparam int TEMP_W     = 16;
	localparam int TARGET_W   = 15;
	localparam int GAIN_W     = 32;
	localparam int DT_W       = 16;
	localparam int ERR_W      = 17;
	localparam int DIFF_W     = ERR_W + 1;
	localparam int INTEG_W    = 48;
	localparam int DUTY_W     = 8;
	localparam int FRAC_BITS  = 16;
	localparam int SPLIT      = 24;
	localparam int MUL_A_W    = 32;
	localparam int MUL_B_W    = 29;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int DIV_W      = 27;
	localparam int DERIV_W    = DIV_W + 1;
	localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
	localparam int ACC_W      = 82;
	localparam int DERIV_SCALE = 1000;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = GAIN_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET = 2'd0,
		REG_KP     = 2'd1,
		REG_KI     = 2'd2,
		REG_KD     = 2'd3
	} cfg_reg_t;

	// Microcode control word
	localparam int PC_W = 4;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_ERR_DT,
		MUL_DIFF_K,
		MUL_KP_ERR,
		MUL_KI_LO,
		MUL_KI_HI,
		MUL_KD_DER
	} mul_op_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_ACCEPT,
		ACT_ERR,
		ACT_INTEG,
		ACT_DIV_INIT,
		ACT_DIV_STEP,
		ACT_DIV_FIX,
		ACT_EMIT
	} act_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_LOAD,
		ACC_ADD,
		ACC_ADD_HI
	} acc_op_t;

	typedef enum logic [2:0] {
		BR_NEVER,
		BR_NO_INPUT,
		BR_DIV_BUSY,
		BR_OUT_BUSY,
		BR_ALWAYS
	} br_t;

	typedef struct packed {
		mul_op_t         mul;
		act_t            act;
		acc_op_t         acc;
		br_t             br;
		logic [PC_W-1:0] target;
	} ctrl_t;

	localparam logic [PC_W-1:0] STEP_IDLE    = 4'd0;
	localparam logic [PC_W-1:0] STEP_ERR     = 4'd1;
	localparam logic [PC_W-1:0] STEP_ERR_DT  = 4'd2;
	localparam logic [PC_W-1:0] STEP_INTEG   = 4'd3;
	localparam logic [PC_W-1:0] STEP_DIV_INI = 4'd4;
	localparam logic [PC_W-1:0] STEP_DIV     = 4'd5;
	localparam logic [PC_W-1:0] STEP_KI_LO   = 4'd6;
	localparam logic [PC_W-1:0] STEP_KI_HI   = 4'd7;
	localparam logic [PC_W-1:0] STEP_KD      = 4'd8;
	localparam logic [PC_W-1:0] STEP_SUM     = 4'd9;
	localparam logic [PC_W-1:0] STEP_OUT_WT  = 4'd10;
	localparam logic [PC_W-1:0] STEP_EMIT    = 4'd11;

	function automatic ctrl_t uc(mul_op_t m, act_t a, acc_op_t c, br_t b,
			logic [PC_W-1:0] t);
		return '{mul: m, act: a, acc: c, br: b, target: t};
	endfunction

	// Program: one control word per step
	function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
		ctrl_t w;
		unique case (pc)
			STEP_IDLE:    w = uc(MUL_NONE,   ACT_ACCEPT,   ACC_NONE,   BR_NO_INPUT, STEP_IDLE);
			STEP_ERR:     w = uc(MUL_NONE,   ACT_ERR,      ACC_NONE,   BR_NEVER,    STEP_IDLE);
			STEP_ERR_DT:  w = uc(MUL_ERR_DT, ACT_NONE,     ACC_NONE,   BR_NEVER,    STEP_IDLE);
			STEP_INTEG:   w = uc(MUL_DIFF_K, ACT_INTEG,    ACC_NONE,   BR_NEVER,    STEP_IDLE);
			STEP_DIV_INI: w = uc(MUL_KP_ERR, ACT_DIV_INIT, ACC_NONE,   BR_NEVER,    STEP_IDLE);
			STEP_DIV:     w = uc(MUL_NONE,   ACT_DIV_STEP, ACC_NONE,   BR_DIV_BUSY, STEP_DIV);
			STEP_KI_LO:   w = uc(MUL_KI_LO,  ACT_DIV_FIX,  ACC_LOAD,   BR_NEVER,    STEP_IDLE);
			STEP_KI_HI:   w = uc(MUL_KI_HI,  ACT_NONE,     ACC_ADD,    BR_NEVER,    STEP_IDLE);
			STEP_KD:      w = uc(MUL_KD_DER, ACT_NONE,     ACC_ADD_HI, BR_NEVER,    STEP_IDLE);
			STEP_SUM:     w = uc(MUL_NONE,   ACT_NONE,     ACC_ADD,    BR_NEVER,    STEP_IDLE);
			STEP_OUT_WT:  w = uc(MUL_NONE,   ACT_NONE,     ACC_NONE,   BR_OUT_BUSY, STEP_OUT_WT);
			STEP_EMIT:    w = uc(MUL_NONE,   ACT_EMIT,     ACC_NONE,   BR_ALWAYS,   STEP_IDLE);
			default:      w = uc(MUL_NONE,   ACT_NONE,     ACC_NONE,   BR_ALWAYS,   STEP_IDLE);
		endcase
		return w;
	endfunction

endpackage

FILE: design/tpid_sample_if.sv
interface tpid_sample_if
	import tpid_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [ADC_W-1:0] adc_sample;
	logic [DT_W-1:0]  elapsed_ms;

	modport source (output valid, adc_sample, elapsed_ms, input ready);
	modport sink   (input valid, adc_sample, elapsed_ms, output ready);
endinterface

FILE: design/tpid_result_if.sv
interface tpid_result_if
	import tpid_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [DUTY_W-1:0]         heater_duty;
	logic signed [TEMP_W-1:0]  measured_temperature;
	logic signed [ERR_W-1:0]   current_error;
	logic signed [INTEG_W-1:0] integral_value;

	modport source (output valid, heater_duty, measured_temperature, current_error,
		integral_value, input ready);
	modport sink   (input valid, heater_duty, measured_temperature, current_error,
		integral_value, output ready);
endinterface

FILE: design/tpid_temp_rom.sv
module tpid_temp_rom
	import tpid_pkg::*;
(
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [ADC_W-1:0]         addr,
	output logic signed [TEMP_W-1:0] temp
);

	// log2 in Q16: integer part from the leading one, 16 fraction bits by squaring
	function automatic longint log2_q16(longint unsigned x);
		int n;
		int b;
		longint unsigned y;
		longint r;
		n = 63;
		while (n > 0 && ((x >> n) & 64'd1) == 64'd0)
			n--;
		y = (n > 30) ? (x >> (n - 30)) : (x << (30 - n));
		r = longint'(n) * 65536;
		for (b = 15; b >= 0; b--) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				y = y >> 1;
				r = r + (longint'(1) << b);
			end
		end
		return r;
	endfunction

	function automatic logic signed [TEMP_W-1:0] temp_of(longint a);
		longint fs;
		longint l;
		longint t;
		fs = (longint'(1) << ADC_BITS) - 1;
		if (a == 0) begin
			t = -32768;
		end else if (a >= fs) begin
			t = 32767;
		end else begin
			l = log2_q16(longint'(SERIES_RESISTOR_OHMS) * (fs - a)) - log2_q16(a);
			t = (TEMP_A_Q16 * 65536 - TEMP_B_Q16 * l + (longint'(1) <<< 31)) >>> 32;
			if (t > 32767)
				t = 32767;
			if (t < -32768)
				t = -32768;
		end
		return TEMP_W'(t);
	endfunction

	// Table entries are folded to constants at elaboration
	logic signed [TEMP_W-1:0] temp_tab [ADC_DEPTH];

	for (genvar g = 0; g < ADC_DEPTH; g++) begin : g_tab
		localparam logic signed [TEMP_W-1:0] ENTRY = temp_of(longint'(g));
		assign temp_tab[g] = ENTRY;
	end

	logic signed [TEMP_W-1:0] temp_q;

	always_ff @(posedge clk) begin
		if (rd_en)
			temp_q <= temp_tab[addr];
	end

	assign temp = temp_q;

endmodule

FILE: design/thermistor_pid_heater_control.sv
// Channel    Dir  Payload                                               Request when
// sample     in   adc_sample[9:0], elapsed_ms[15:0]                     valid & ready
// result     out  heater_duty[7:0], measured_temperature[15:0] s,       valid & ready
//                 current_error[16:0] s, integral_value[47:0] s
// cfg        in   cfg_write, cfg_index[1:0], cfg_data[31:0]             cfg_write
//
// One request at a time: after a request is taken, the program forms the error,
// the integral, the derivative by the 27-step shift-subtract divider and the
// gain sum, then loads the result. The next request is taken the cycle after
// the result is loaded; a held result stalls the program at its last wait
// step. arst_n clears the sequencer, the registers, the integral, the previous
// error and the result valid.
module thermistor_pid_heater_control
	import tpid_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	tpid_sample_if.sink           sample,
	tpid_result_if.source         result,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

	// Sequencer
	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	ctrl_t           ctrl;
	logic            br_take;
	logic            accept;

	// Configuration
	logic [TARGET_W-1:0]      target_q;
	logic signed [GAIN_W-1:0] kp_q;
	logic signed [GAIN_W-1:0] ki_q;
	logic signed [GAIN_W-1:0] kd_q;

	// Datapath
	logic signed [TEMP_W-1:0]  rom_temp;
	logic [DT_W-1:0]           dt_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [ERR_W-1:0]   err_next;
	logic signed [ERR_W-1:0]   prev_q;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [INTEG_W+1:0] integ_base;
	logic signed [INTEG_W+1:0] integ_sum;
	logic signed [INTEG_W-1:0] integ_next;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic signed [PROD_W-1:0]  p_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   acc_add;

	// Derivative divider
	logic [DIV_CNT_W-1:0]      div_cnt_q;
	logic [DT_W-1:0]           div_rem_q;
	logic [DIV_W-1:0]          div_quo_q;
	logic                      div_neg_q;
	logic [DT_W:0]             div_trial;
	logic [DT_W:0]             div_diff;
	logic                      div_ge;
	logic signed [DERIV_W-1:0] div_num;
	logic signed [DERIV_W-1:0] div_mag;
	logic signed [DERIV_W-1:0] deriv_q;

	// Result register
	logic                      out_valid_q;
	logic [DUTY_W-1:0]         duty;
	logic [DUTY_W-1:0]         duty_q;
	logic signed [TEMP_W-1:0]  temp_out_q;
	logic signed [ERR_W-1:0]   err_out_q;
	logic signed [INTEG_W-1:0] integ_out_q;

	assign ctrl         = ucode(pc_q);
	assign sample.ready = (ctrl.act == ACT_ACCEPT);
	assign accept       = sample.valid & sample.ready;

	tpid_temp_rom u_rom (
		.clk   (clk),
		.rd_en (accept),
		.addr  (sample.adc_sample),
		.temp  (rom_temp)
	);

	// Branch: take the target when the condition holds, else fall through
	always_comb begin
		unique case (ctrl.br)
			BR_NEVER:    br_take = 1'b0;
			BR_NO_INPUT: br_take = !accept;
			BR_DIV_BUSY: br_take = (div_cnt_q != DIV_CNT_W'(1));
			BR_OUT_BUSY: br_take = out_valid_q & !result.ready;
			BR_ALWAYS:   br_take = 1'b1;
			default:     br_take = 1'b0;
		endcase
		pc_next = br_take ? ctrl.target : pc_q + 1'b1;
	end

	// Error from setpoint and looked-up temperature
	assign err_next = $signed({2'b00, target_q}) - ERR_W'(rom_temp);
	assign diff     = DIFF_W'(err_q) - DIFF_W'(prev_q);

	// Shared multiplier operand select; Ki * integral goes in two 24-bit halves
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctrl.mul)
			MUL_NONE: begin
			end
			MUL_ERR_DT: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = $signed(MUL_B_W'(dt_q));
			end
			MUL_DIFF_K: begin
				mul_a = MUL_A_W'(diff);
				mul_b = MUL_B_W'(DERIV_SCALE);
			end
			MUL_KP_ERR: begin
				mul_a = kp_q;
				mul_b = MUL_B_W'(err_q);
			end
			MUL_KI_LO: begin
				mul_a = ki_q;
				mul_b = $signed(MUL_B_W'(integ_q[SPLIT-1:0]));
			end
			MUL_KI_HI: begin
				mul_a = ki_q;
				mul_b = MUL_B_W'($signed(integ_q[INTEG_W-1:SPLIT]));
			end
			MUL_KD_DER: begin
				mul_a = kd_q;
				mul_b = MUL_B_W'(deriv_q);
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Integral: zero setpoint clears it before the add, then saturate to 48 bits
	always_comb begin
		integ_base = (target_q == '0) ? '0 : (INTEG_W+2)'(integ_q);
		integ_sum  = integ_base + $signed(p_q[INTEG_W+1:0]);
		if (integ_sum[INTEG_W+1:INTEG_W-1] == 3'b000 ||
				integ_sum[INTEG_W+1:INTEG_W-1] == 3'b111)
			integ_next = integ_sum[INTEG_W-1:0];
		else if (integ_sum[INTEG_W+1])
			integ_next = INTEG_MIN;
		else
			integ_next = INTEG_MAX;
	end

	// Restoring divider on magnitudes; dt is never zero here
	assign div_trial = {div_rem_q, div_quo_q[DIV_W-1]};
	assign div_ge    = (div_trial >= {1'b0, dt_q});
	assign div_diff  = div_trial - {1'b0, dt_q};
	assign div_num   = p_q[DERIV_W-1:0];
	assign div_mag   = p_q[PROD_W-1] ? -div_num : div_num;

	// High half of Ki * integral lands 24 bits up
	assign acc_add = (ctrl.acc == ACC_ADD_HI) ? (ACC_W'(p_q) <<< SPLIT) : ACC_W'(p_q);

	// Duty: negative sum gives zero, else sum >> 16 limited to full scale
	always_comb begin
		if (acc_q[ACC_W-1])
			duty = '0;
		else if (|acc_q[ACC_W-2:FRAC_BITS+DUTY_W])
			duty = '1;
		else
			duty = acc_q[FRAC_BITS+DUTY_W-1:FRAC_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_IDLE;
			target_q    <= '0;
			kp_q        <= '0;
			ki_q        <= '0;
			kd_q        <= '0;
			integ_q     <= '0;
			prev_q      <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_next;

			if (ctrl.act == ACT_INTEG)
				integ_q <= integ_next;

			if (ctrl.act == ACT_DIV_INIT) begin
				prev_q    <= err_q;
				div_cnt_q <= DIV_CNT_W'(DIV_W);
			end else if (ctrl.act == ACT_DIV_STEP) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end

			if (ctrl.act == ACT_EMIT)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;

			// Writes must come only while idle; the block itself does not enforce this. A setpoint write restarts the integral
			if (cfg_write) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_TARGET: begin
						target_q <= cfg_data[TARGET_W-1:0];
						integ_q  <= '0;
					end
					REG_KP:  kp_q <= cfg_data;
					REG_KI:  ki_q <= cfg_data;
					REG_KD:  kd_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			dt_q <= (sample.elapsed_ms == '0) ? DT_W'(1) : sample.elapsed_ms;

		if (ctrl.mul != MUL_NONE)
			p_q <= mul_p;

		case (ctrl.acc)
			ACC_LOAD:               acc_q <= ACC_W'(p_q);
			ACC_ADD, ACC_ADD_HI:    acc_q <= acc_q + acc_add;
			default: begin
			end
		endcase

		case (ctrl.act)
			ACT_ERR: err_q <= err_next;
			ACT_DIV_INIT: begin
				div_neg_q <= p_q[PROD_W-1];
				div_quo_q <= div_mag[DIV_W-1:0];
				div_rem_q <= '0;
			end
			ACT_DIV_STEP: begin
				div_rem_q <= div_ge ? div_diff[DT_W-1:0] : div_trial[DT_W-1:0];
				div_quo_q <= {div_quo_q[DIV_W-2:0], div_ge};
			end
			ACT_DIV_FIX: begin
				deriv_q <= div_neg_q ? -$signed(DERIV_W'(div_quo_q))
					: $signed(DERIV_W'(div_quo_q));
			end
			ACT_EMIT: begin
				duty_q      <= duty;
				temp_out_q  <= rom_temp;
				err_out_q   <= err_q;
				integ_out_q <= integ_q;
			end
			default: begin
			end
		endcase
	end

	assign result.valid                = out_valid_q;
	assign result.heater_duty          = duty_q;
	assign result.measured_temperature = temp_out_q;
	assign result.current_error        = err_out_q;
	assign result.integral_value       = integ_out_q;

endmodule

FILE: bench/tb_thermistor_pid_heater_control.sv
`timescale 1ns / 100ps

module tb_thermistor_pid_heater_control;
	import tpid_pkg::*;

	// One sample request: converter reading plus elapsed time
	typedef struct packed {
		logic [ADC_W-1:0] adc;
		logic [DT_W-1:0]  ms;
	} adc_req_t;

	// One control update as the result channel should carry it
	typedef struct packed {
		logic [DUTY_W-1:0]         duty;
		logic signed [TEMP_W-1:0]  temp;
		logic signed [ERR_W-1:0]   err;
		logic signed [INTEG_W-1:0] integ;
	} duty_result_t;

	localparam longint INTEG_TOP = (longint'(1) <<< 47) - 1;
	localparam longint INTEG_BOT = -(longint'(1) <<< 47);
	localparam logic signed [127:0] KI_PROD_CAP = 128'sd1 <<< 61;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 40;
	// Back-to-back full-error steps at the longest time step
	localparam int SAT_STEPS = 48;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tpid_sample_if smp();
	tpid_result_if res();

	thermistor_pid_heater_control uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (smp),
		.result    (res),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Requests waiting to go out, and control updates waiting to come back
	adc_req_t     samples_to_send[$];
	duty_result_t updates_due[$];
	adc_req_t     next_req;

	// Controller state as the bench tracks it
	longint tgt_set   = 0;
	longint kp_set    = 0;
	longint ki_set    = 0;
	longint kd_set    = 0;
	longint integ_acc = 0;
	longint last_err  = 0;

	bit steady = 1'b0;
	int fault_count = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// log2 of x >= 1 in Q16: integer part from the leading one, fraction bits
	// by repeated squaring of a Q30 mantissa
	function automatic longint log2_fix16(longint unsigned x);
		int n;
		longint unsigned y;
		longint r;
		n = 63;
		while (n > 0 && !x[n])
			n--;
		y = (n > 30) ? (x >> (n - 30)) : (x << (30 - n));
		r = longint'(n) * 65536;
		for (int b = 15; b >= 0; b--) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				y = y >> 1;
				r += longint'(1) << b;
			end
		end
		return r;
	endfunction

	// Divider reading to temperature in 1/64 degree, clamped at both rails
	function automatic logic signed [TEMP_W-1:0] adc_to_temp(logic [ADC_W-1:0] a);
		longint unsigned full;
		longint l;
		longint t;
		full = (64'd1 << ADC_BITS) - 1;
		if (a == 0)
			return 16'sh8000;
		if (a >= full)
			return 16'sh7FFF;
		l = log2_fix16(longint'(SERIES_RESISTOR_OHMS) * (full - a)) - log2_fix16(a);
		t = (TEMP_A_Q16 * 65536 - TEMP_B_Q16 * l + (longint'(1) <<< 31)) >>> 32;
		if (t > 32767)
			t = 32767;
		if (t < -32768)
			t = -32768;
		return 16'(t);
	endfunction

	// One PID update; advances the tracked integral and previous error
	function automatic duty_result_t compute_control_update(logic [ADC_W-1:0] a,
			logic [DT_W-1:0] ms);
		duty_result_t r;
		longint dt;
		longint temp;
		longint err;
		longint deriv;
		logic signed [127:0] ki_term;
		logic signed [127:0] sum;
		logic signed [127:0] d;
		dt = ms;
		if (dt == 0)
			dt = 1;
		temp = adc_to_temp(a);
		err = tgt_set - temp;

		// zero setpoint holds the integral cleared
		if (tgt_set == 0)
			integ_acc = 0;
		integ_acc += err * dt;
		if (integ_acc > INTEG_TOP)
			integ_acc = INTEG_TOP;
		if (integ_acc < INTEG_BOT)
			integ_acc = INTEG_BOT;

		// division truncates toward zero
		deriv = ((err - last_err) * 1000) / dt;
		last_err = err;

		ki_term = ki_set;
		ki_term = ki_term * integ_acc;
		if (ki_term > KI_PROD_CAP)
			ki_term = KI_PROD_CAP;
		if (ki_term < -KI_PROD_CAP)
			ki_term = -KI_PROD_CAP;
		sum = ki_term;
		sum = sum + kp_set * err + kd_set * deriv;

		if (sum < 0) begin
			d = 0;
		end else begin
			d = sum >>> 16;
			if (d > 255)
				d = 255;
		end
		r.duty = 8'(d);
		r.temp = 16'(temp);
		r.err = 17'(err);
		r.integ = 48'(integ_acc);
		return r;
	endfunction

	// Random request: mostly near the operating point so duties land mid-range,
	// the rest anywhere, with the rails and odd time steps mixed in
	function automatic adc_req_t rand_req(logic [ADC_W-1:0] center);
		adc_req_t q;
		int roll;
		int spot;
		roll = $urandom_range(99);
		if (roll < 60) begin
			spot = int'(center) + int'($urandom_range(32)) - 16;
			if (spot < 0)
				spot = 0;
			if (spot > ADC_DEPTH - 1)
				spot = ADC_DEPTH - 1;
			q.adc = ADC_W'(spot);
		end else if (roll < 92) begin
			q.adc = ADC_W'($urandom_range(ADC_DEPTH - 1));
		end else begin
			spot = $urandom_range(3);
			q.adc = (spot < 2) ? ADC_W'(spot) : ADC_W'(ADC_DEPTH - 4 + spot);
		end
		roll = $urandom_range(99);
		if (roll < 50)
			q.ms = DT_W'($urandom_range(200, 1));
		else if (roll < 75)
			q.ms = DT_W'($urandom_range(5000));
		else if (roll < 92)
			q.ms = DT_W'($urandom);
		else if (roll < 96)
			q.ms = '0;
		else
			q.ms = '1;
		return q;
	endfunction

	// Gains: mostly small enough to keep the duty off the rails
	function automatic logic [31:0] pick_gain(int span);
		int roll;
		roll = $urandom_range(99);
		if (roll < 50)
			return $urandom_range(2 * span) - span;
		if (roll < 70)
			return $urandom_range(2 * span * 256) - span * 256;
		if (roll < 85)
			return $urandom;
		if (roll < 92)
			return 32'h0;
		return roll[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
	endfunction

	// Register write; the tracked copy follows right away since nothing is in flight
	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_TARGET: begin
				tgt_set = val[TARGET_W-1:0];
				integ_acc = 0;
			end
			REG_KP: kp_set = $signed(val);
			REG_KI: ki_set = $signed(val);
			REG_KD: kd_set = $signed(val);
		endcase
	endtask

	task automatic apply_settings(bit with_target, logic [31:0] tgt_word,
			logic [31:0] kp_word, logic [31:0] ki_word, logic [31:0] kd_word);
		if (with_target)
			write_reg(REG_TARGET, tgt_word);
		write_reg(REG_KP, kp_word);
		write_reg(REG_KI, ki_word);
		write_reg(REG_KD, kd_word);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Hold off until every request is out and every update has come back
	task automatic drain();
		while (samples_to_send.size() != 0 || smp.valid || updates_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			fault_count++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Sample driver: a request stays up until taken, then the next one or a gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp.valid <= 1'b0;
			smp.adc_sample <= '0;
			smp.elapsed_ms <= '0;
		end else begin
			if (smp.valid && smp.ready)
				updates_due.push_back(compute_control_update(smp.adc_sample, smp.elapsed_ms));
			if (!smp.valid || smp.ready) begin
				if (samples_to_send.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
					next_req = samples_to_send.pop_front();
					smp.valid <= 1'b1;
					smp.adc_sample <= next_req.adc;
					smp.elapsed_ms <= next_req.ms;
				end else begin
					smp.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				if (updates_due.size() == 0) begin
					fault_count++;
					$display("%0t: unexpected result, expected none, got duty %0d", $time,
						res.heater_duty);
				end else begin
					check_field("heater_duty", updates_due[0].duty, res.heater_duty);
					check_field("measured_temperature", updates_due[0].temp,
						res.measured_temperature);
					check_field("current_error", updates_due[0].err, res.current_error);
					check_field("integral_value", updates_due[0].integ, res.integral_value);
					void'(updates_due.pop_front());
				end
			end
			res.ready <= steady || ($urandom_range(99) >= 30);
		end
	end

	// Watchdog: too long without any request moving on either side
	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [ADC_W-1:0] center;
		longint goal;
		logic [31:0] tgt_word;
		int roll;

		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero gains and setpoint, duty must sit at 0
		samples_to_send.push_back('{10'd0, 16'd0});
		samples_to_send.push_back('{10'd1023, 16'd65535});
		samples_to_send.push_back('{10'd512, 16'd1});
		drain();

		// Top setpoint (upper data bits set, must be dropped), extreme gains,
		// both converter rails, zero and full time steps; Ki product saturates
		apply_settings(1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		samples_to_send.push_back('{10'd0, 16'd65535});
		samples_to_send.push_back('{10'd1, 16'd1});
		samples_to_send.push_back('{10'd2, 16'd0});
		samples_to_send.push_back('{10'd1021, 16'd100});
		samples_to_send.push_back('{10'd1022, 16'd7});
		samples_to_send.push_back('{10'd1023, 16'd65535});
		samples_to_send.push_back('{10'd511, 16'd1000});
		samples_to_send.push_back('{10'd512, 16'd0});
		drain();

		// Zero setpoint: integral cleared before every update, errors of both signs
		apply_settings(1'b1, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		samples_to_send.push_back('{10'd1023, 16'd1});
		samples_to_send.push_back('{10'd700, 16'd50});
		samples_to_send.push_back('{10'd1, 16'd65535});
		samples_to_send.push_back('{10'd0, 16'd3});
		samples_to_send.push_back('{10'd300, 16'd0});
		drain();

		// Around 40 degrees with modest gains so the duty lands mid-range
		apply_settings(1'b1, 32'd2560, 32'h0000_1000, 32'h0000_0010, 32'hFFFF_FF00);
		samples_to_send.push_back('{10'd100, 16'd10});
		samples_to_send.push_back('{10'd102, 16'd20});
		samples_to_send.push_back('{10'd104, 16'd0});
		samples_to_send.push_back('{10'd98, 16'd250});
		samples_to_send.push_back('{10'd110, 16'd1});
		samples_to_send.push_back('{10'd95, 16'd65535});
		drain();

		// Random phases, each with its own operating point; the setpoint is
		// sometimes left alone so the integral carries across a gain change
		for (int ph = 0; ph < 8; ph++) begin
			center = ADC_W'($urandom_range(ADC_DEPTH - 1));
			roll = $urandom_range(99);
			if (roll < 70) begin
				goal = adc_to_temp(center);
				goal = goal + longint'($urandom_range(1024)) - 512;
				if (goal < 0)
					goal = 0;
				if (goal > 32767)
					goal = 32767;
			end else if (roll < 80) begin
				goal = 0;
			end else if (roll < 90) begin
				goal = 32767;
			end else begin
				goal = $urandom_range(32767);
			end
			tgt_word = $urandom;
			tgt_word[TARGET_W-1:0] = TARGET_W'(goal);
			apply_settings(ph == 0 || $urandom_range(3) != 0, tgt_word,
				pick_gain(4096), pick_gain(256), pick_gain(256));
			repeat (235) samples_to_send.push_back(rand_req(center));
			drain();
		end

		// Full error at the longest step with a large Ki, so the duty pins high,
		// run with no idling on either side
		steady = 1'b1;
		apply_settings(1'b1, 32'd32767, 32'h0000_0100, 32'h7FFF_FFFF, 32'h0000_0001);
		repeat (SAT_STEPS) samples_to_send.push_back('{10'd0, 16'd65535});
		samples_to_send.push_back('{10'd1023, 16'd65535});
		samples_to_send.push_back('{10'd0, 16'd0});
		drain();
		steady = 1'b0;

		if (fault_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: thermistor_pid_heater_control.f
design/tpid_pkg.sv
design/tpid_sample_if.sv
design/tpid_result_if.sv
design/tpid_temp_rom.sv
design/thermistor_pid_heater_control.sv
bench/tb_thermistor_pid_heater_control.sv
